>>> rtl/ramdisk_slot_chain_mapper_core_defines.svh
// assertion macros for the ram drive slot chain mapper
`ifndef RAMDISK_SLOT_CHAIN_MAPPER_CORE_DEFINES_SVH
`define RAMDISK_SLOT_CHAIN_MAPPER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RSCM_ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rscm assertion failed");
`define RSCM_ASSERT_NEVER(lbl, cond) \
  `RSCM_ASSERT_CLK(lbl, !(cond))
`else
`define RSCM_ASSERT_CLK(lbl, prop)
`define RSCM_ASSERT_NEVER(lbl, cond)
`endif

`endif

>>> rtl/rscm_pkg.sv
// types and constants of the ram drive slot chain mapper
package rscm_pkg;

  localparam int Drives      = 2;
  localparam int Slots       = 8;
  localparam int SlotSectors = 128;
  localparam int MaxBurst    = 16;

  localparam int DriveW   = 1;
  localparam int KbW      = 10;
  localparam int StartW   = 16;
  localparam int CountW   = 5;
  localparam int StatusW  = 3;
  localparam int SlotIdxW = 3;
  localparam int OffW     = 7;
  localparam int DrvSzW   = 11;

  localparam int SlotW   = $clog2(Slots);
  localparam int LinkW   = SlotW + 1;
  localparam int SecW    = $clog2(SlotSectors + 1);
  localparam int ChunkKb = SlotSectors / 2;
  localparam int ChunkW  = $clog2(ChunkKb);
  localparam int NeedW   = KbW + 1 - ChunkW;
  localparam int StepW   = $clog2(Slots + 1);

  localparam logic [LinkW-1:0] LinkNone = '1;

  typedef enum logic [1:0] {
    ReqCreate,
    ReqDestroy,
    ReqRead,
    ReqWrite
  } req_type_e;

  typedef enum logic [StatusW-1:0] {
    StOk,
    StBusy,
    StNoMem,
    StInvalid,
    StRange
  } status_e;

  typedef enum logic [2:0] {
    Idle,
    CountFree,
    Alloc,
    FreeChain,
    Walk
  } state_e;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [DriveW-1:0] drive;
    logic [KbW-1:0]    size_kb;
    logic [StartW-1:0] start_sector;
    logic [CountW-1:0] sector_count;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [SlotIdxW-1:0] slot_index;
    logic [OffW-1:0]     slot_offset;
    logic                is_write;
    logic [DrvSzW-1:0]   drive_size;
    logic                last;
  } res_t;

endpackage

>>> rtl/ramdisk_slot_chain_mapper_core.sv
// ram drive slot chain mapper: slot allocation, chain release and sector mapping
//
//  channel  | signals                  | direction | handshake
//  request  | start, busy, req_i       | in        | taken when start high and busy low
//  result   | done_o, res_o            | out       | one cycle strobe, never held off
//  config   | cfg_we_i, cfg_wdata_i    | in        | written when cfg_we_i high
//
// one slot table entry is read per cycle through a single shared compare/subtract unit
// create: decode, a free count pass over every slot table entry, then an allocation pass up to the
// last slot taken; destroy: decode, then a release of each chained slot in turn, then the result
// read/write: decode, a walk over each slot boundary crossed, then one result per sector
// reset empties every drive and frees every slot at once; disk enable resets to 1
// results go out through an output register; one item is worked at a time
`include "ramdisk_slot_chain_mapper_core_defines.svh"

module ramdisk_slot_chain_mapper_core
  import rscm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic done_o,
  output res_t res_o,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i
);

  state_e state_q, state_d;
  logic   en_q, en_d;
  logic   done_q, done_d;
  res_t   res_q, res_d;

  logic [Drives-1:0]             drv_valid_q, drv_valid_d;
  logic [SlotW-1:0]              drv_first_q [Drives];
  logic [SlotW-1:0]              drv_first_d [Drives];
  logic [DrvSzW-1:0]             drv_sec_q [Drives];
  logic [DrvSzW-1:0]             drv_sec_d [Drives];
  logic [SecW-1:0]               slot_sec_q [Slots];
  logic [SecW-1:0]               slot_sec_d [Slots];
  logic [LinkW-1:0]              slot_link_q [Slots];
  logic [LinkW-1:0]              slot_link_d [Slots];

  logic [LinkW-1:0]  cur_q, cur_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [NeedW-1:0]  cnt_q, cnt_d;
  logic [NeedW-1:0]  need_q, need_d;
  logic [ChunkW-1:0] rem_q, rem_d;
  logic [SlotW-1:0]  prev_q, prev_d;
  logic [DrvSzW-1:0] off_q, off_d;
  logic [CountW-1:0] left_q, left_d;
  logic [DriveW-1:0] drv_q, drv_d;
  logic              wr_q, wr_d;

  // shared slot read and arithmetic
  logic              cur_ok;
  logic [SecW-1:0]   sec;
  logic [LinkW-1:0]  link;
  logic [DrvSzW-1:0] sec_ext;
  logic [NeedW-1:0]  cnt_next;
  logic              last_chunk;
  logic [SecW-1:0]   alloc_secs;
  logic [DrvSzW-1:0] size_new;
  logic              steps_left;

  // request decode
  logic              req_drv_ok;
  logic [NeedW-1:0]  req_need;
  logic [StartW:0]   req_end;
  logic              req_range_bad;

  assign cur_ok     = cur_q < LinkW'(Slots);
  assign sec        = cur_ok ? slot_sec_q[cur_q[SlotW-1:0]] : '0;
  assign link       = cur_ok ? slot_link_q[cur_q[SlotW-1:0]] : LinkNone;
  assign sec_ext    = DrvSzW'(sec);
  assign cnt_next   = cnt_q + ((sec == '0) ? NeedW'(1) : NeedW'(0));
  assign last_chunk = (cnt_q + NeedW'(1)) == need_q;
  assign alloc_secs = (last_chunk && rem_q != '0) ? SecW'({rem_q, 1'b0})
                                                  : SecW'(SlotSectors);
  assign size_new   = drv_sec_q[drv_q] + DrvSzW'(alloc_secs);
  assign steps_left = step_q < StepW'(Slots);

  assign req_drv_ok    = 32'(req_i.drive) < Drives;
  assign req_need      = NeedW'((11'(req_i.size_kb) + 11'(ChunkKb - 1)) >> ChunkW);
  assign req_end       = {1'b0, req_i.start_sector} + (StartW + 1)'(req_i.sector_count);
  assign req_range_bad = req_end > (StartW + 1)'(drv_sec_q[req_i.drive]);

  assign busy   = state_q != Idle;
  assign done_o = done_q;
  assign res_o  = res_q;

  always_comb begin
    state_d     = state_q;
    en_d        = cfg_we_i ? cfg_wdata_i : en_q;
    done_d      = 1'b0;
    res_d       = res_q;
    drv_valid_d = drv_valid_q;
    drv_first_d = drv_first_q;
    drv_sec_d   = drv_sec_q;
    slot_sec_d  = slot_sec_q;
    slot_link_d = slot_link_q;
    cur_d       = cur_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    need_d      = need_q;
    rem_d       = rem_q;
    prev_d      = prev_q;
    off_d       = off_q;
    left_d      = left_q;
    drv_d       = drv_q;
    wr_d        = wr_q;

    unique case (state_q)
      Idle: begin
        if (start) begin
          drv_d = req_i.drive;
          wr_d  = req_type_e'(req_i.req_type) == ReqWrite;
          res_d.status      = StOk;
          res_d.slot_index  = '0;
          res_d.slot_offset = '0;
          res_d.is_write    = req_type_e'(req_i.req_type) == ReqWrite;
          res_d.drive_size  = drv_sec_q[req_i.drive];
          res_d.last        = 1'b1;
          unique case (req_type_e'(req_i.req_type))
            ReqCreate: begin
              if (!req_drv_ok) begin
                res_d.status     = StInvalid;
                res_d.drive_size = '0;
                done_d           = 1'b1;
              end else if (drv_valid_q[req_i.drive]) begin
                res_d.status = StBusy;
                done_d       = 1'b1;
              end else if (req_i.size_kb == '0) begin
                res_d.status = StInvalid;
                done_d       = 1'b1;
              end else begin
                need_d  = req_need;
                rem_d   = req_i.size_kb[ChunkW-1:0];
                cur_d   = '0;
                cnt_d   = '0;
                state_d = CountFree;
              end
            end
            ReqDestroy: begin
              if (!req_drv_ok) begin
                res_d.status     = StInvalid;
                res_d.drive_size = '0;
                done_d           = 1'b1;
              end else if (drv_valid_q[req_i.drive]) begin
                cur_d   = LinkW'(drv_first_q[req_i.drive]);
                off_d   = drv_sec_q[req_i.drive];
                step_d  = '0;
                state_d = FreeChain;
              end else begin
                res_d.status = StInvalid;
                done_d       = 1'b1;
              end
            end
            ReqRead, ReqWrite: begin
              if (!req_drv_ok) begin
                res_d.status     = StRange;
                res_d.drive_size = '0;
                done_d           = 1'b1;
              end else if (!en_q || !drv_valid_q[req_i.drive] ||
                           32'(req_i.sector_count) > MaxBurst || req_range_bad) begin
                res_d.status = StRange;
                done_d       = 1'b1;
              end else if (req_i.sector_count == '0) begin
                done_d = 1'b1;
              end else begin
                cur_d   = LinkW'(drv_first_q[req_i.drive]);
                off_d   = req_i.start_sector[DrvSzW-1:0];
                left_d  = req_i.sector_count;
                step_d  = '0;
                state_d = Walk;
              end
            end
            default: ;
          endcase
        end
      end

      CountFree: begin
        if (cur_q == LinkW'(Slots - 1)) begin
          drv_sec_d[drv_q] = '0;
          if (cnt_next < need_q) begin
            res_d.status      = StNoMem;
            res_d.slot_index  = '0;
            res_d.slot_offset = '0;
            res_d.is_write    = wr_q;
            res_d.drive_size  = '0;
            res_d.last        = 1'b1;
            done_d            = 1'b1;
            state_d           = Idle;
          end else begin
            cur_d   = '0;
            cnt_d   = '0;
            state_d = Alloc;
          end
        end else begin
          cnt_d = cnt_next;
          cur_d = cur_q + LinkW'(1);
        end
      end

      Alloc: begin
        cur_d = cur_q + LinkW'(1);
        if (cur_ok && sec == '0) begin
          slot_sec_d[cur_q[SlotW-1:0]]  = alloc_secs;
          slot_link_d[cur_q[SlotW-1:0]] = LinkNone;
          if (cnt_q == '0) begin
            drv_first_d[drv_q] = cur_q[SlotW-1:0];
          end else begin
            slot_link_d[prev_q] = cur_q;
          end
          prev_d           = cur_q[SlotW-1:0];
          cnt_d            = cnt_q + NeedW'(1);
          drv_sec_d[drv_q] = size_new;
          if (last_chunk) begin
            drv_valid_d[drv_q] = 1'b1;
            res_d.status       = StOk;
            res_d.slot_index   = '0;
            res_d.slot_offset  = '0;
            res_d.is_write     = wr_q;
            res_d.drive_size   = size_new;
            res_d.last         = 1'b1;
            done_d             = 1'b1;
            state_d            = Idle;
          end
        end
      end

      FreeChain: begin
        if (steps_left && off_q != '0 && cur_ok && sec != '0) begin
          off_d                          = (sec_ext >= off_q) ? '0 : off_q - sec_ext;
          cur_d                          = link;
          slot_sec_d[cur_q[SlotW-1:0]]   = '0;
          slot_link_d[cur_q[SlotW-1:0]]  = LinkNone;
          step_d                         = step_q + StepW'(1);
        end else begin
          drv_valid_d[drv_q] = 1'b0;
          drv_sec_d[drv_q]   = '0;
          res_d.status       = StOk;
          res_d.slot_index   = '0;
          res_d.slot_offset  = '0;
          res_d.is_write     = wr_q;
          res_d.drive_size   = '0;
          res_d.last         = 1'b1;
          done_d             = 1'b1;
          state_d            = Idle;
        end
      end

      Walk: begin
        if (steps_left && cur_ok && off_q >= sec_ext) begin
          off_d  = off_q - sec_ext;
          cur_d  = link;
          step_d = step_q + StepW'(1);
        end else begin
          res_d.status      = StOk;
          res_d.slot_index  = cur_ok ? SlotIdxW'(cur_q) : '0;
          res_d.slot_offset = off_q[OffW-1:0];
          res_d.is_write    = wr_q;
          res_d.drive_size  = drv_sec_q[drv_q];
          res_d.last        = left_q == CountW'(1);
          done_d            = 1'b1;
          if (left_q == CountW'(1)) begin
            state_d = Idle;
          end else begin
            left_d = left_q - CountW'(1);
            off_d  = off_q + DrvSzW'(1);
          end
        end
      end

      default: state_d = Idle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= Idle;
      en_q        <= 1'b1;
      done_q      <= 1'b0;
      drv_valid_q <= '0;
      for (int d = 0; d < Drives; d++) begin
        drv_first_q[d] <= '0;
        drv_sec_q[d]   <= '0;
      end
      for (int s = 0; s < Slots; s++) begin
        slot_sec_q[s]  <= '0;
        slot_link_q[s] <= LinkNone;
      end
    end else begin
      state_q     <= state_d;
      en_q        <= en_d;
      done_q      <= done_d;
      drv_valid_q <= drv_valid_d;
      drv_first_q <= drv_first_d;
      drv_sec_q   <= drv_sec_d;
      slot_sec_q  <= slot_sec_d;
      slot_link_q <= slot_link_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    cur_q  <= cur_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    need_q <= need_d;
    rem_q  <= rem_d;
    prev_q <= prev_d;
    off_q  <= off_d;
    left_q <= left_d;
    drv_q  <= drv_d;
    wr_q   <= wr_d;
  end

  `RSCM_ASSERT_CLK(a_accept_acts, start && !busy |=> busy || done_o)
  `RSCM_ASSERT_CLK(a_last_ends, done_o && res_o.last |-> !busy)
  `RSCM_ASSERT_NEVER(a_error_single, done_o && res_o.status != StOk && !res_o.last)
  `RSCM_ASSERT_CLK(a_walk_valid_drive, state_q == Walk |-> drv_valid_q[drv_q])

endmodule
